### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the port checks in i2cm_chk.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Concurrent assertion that also checks during reset.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

### rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    localparam int TICK_WIDTH = 10;
    localparam int CFG_WIDTH  = 10;
    localparam int ADDR_WIDTH = 3;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    localparam logic [CFG_WIDTH-1:0] RESET_HIGH_TICKS = 10'd30;
    localparam logic [CFG_WIDTH-1:0] RESET_LOW_TICKS  = 10'd65;

    typedef enum logic [0:0] {
        REG_SCL_HIGH = 1'b0,
        REG_SCL_LOW  = 1'b1
    } t_reg_index;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_ST_A  = 4'd1,
        PH_ST_B  = 4'd2,
        PH_ST_C  = 4'd3,
        PH_ST_D  = 4'd4,
        PH_SP_A  = 4'd5,
        PH_SP_B  = 4'd6,
        PH_SP_C  = 4'd7,
        PH_WR_LO = 4'd8,
        PH_WR_HI = 4'd9,
        PH_RD_LO = 4'd10,
        PH_RD_HI = 4'd11
    } t_phase;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_in;
    } t_in_word;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } t_out_word;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] high_ticks;
        logic [CFG_WIDTH-1:0] low_ticks;
    } t_timing;

endpackage

`default_nettype wire

### rtl/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Open-drain I2C master bit engine with an APB timing register port.
// ----------------------------------------------------------------------------
// Each input word is one tick of the bit sequencer: a command (none, start,
// stop, write byte, read byte), the byte to send, the ACK/NACK choice for
// reads and the sampled SDA level. Every accepted word yields exactly one
// output word with the SCL and SDA pin levels, busy, a done pulse, the last
// received byte and the last acknowledge seen.
// The state update and result logic sit between the input handshake and an
// output register, so a word is accepted every cycle while o_in_stall is low
// and its result is registered in the output register. A skid register behind
// the output register keeps the input side open for one more word when the
// receiver stalls; o_in_stall rises only when both are full.
// Commands are taken only while the engine is idle; SCL half periods come
// from the scl_high_ticks (address 0) and scl_low_ticks (address 4) registers.
// Synchronous reset returns the sequencer to idle with both pins released,
// empties the output stages and loads the timing registers with 30 and 65.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_engine
    import i2cm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_word              i_in_word,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_word                  o_out_word,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_WIDTH-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    t_timing   r_timing;
    t_out_word w_result;
    t_out_word r_out;
    t_out_word r_skid;
    logic      r_out_valid;
    logic      r_skid_valid;
    logic      w_accept;
    logic      w_take;
    logic      w_wr;
    t_reg_index w_idx;

    assign pready = 1'b1;
    assign w_idx  = t_reg_index'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.high_ticks <= RESET_HIGH_TICKS;
            r_timing.low_ticks  <= RESET_LOW_TICKS;
        end else if (w_wr) begin
            if (w_idx == REG_SCL_HIGH) begin
                r_timing.high_ticks <= pwdata[CFG_WIDTH-1:0];
            end else begin
                r_timing.low_ticks <= pwdata[CFG_WIDTH-1:0];
            end
        end
    end

    always_comb begin
        if (w_idx == REG_SCL_HIGH) begin
            prdata = {{(32-CFG_WIDTH){1'b0}}, r_timing.high_ticks};
        end else begin
            prdata = {{(32-CFG_WIDTH){1'b0}}, r_timing.low_ticks};
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign w_accept    = i_in_valid && !r_skid_valid;
    assign w_take      = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    i2cm_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_accept),
        .i_word   (i_in_word),
        .i_timing (r_timing),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_take) begin
                r_out <= w_result;
            end else begin
                r_skid <= w_result;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// Bit sequencer state and the next-state logic for one clock tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_seq
    import i2cm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire t_in_word  i_word,
    input  wire t_timing   i_timing,
    output t_out_word      o_result
);

    typedef struct packed {
        t_phase                phase;
        logic [3:0]            bit_index;
        logic [7:0]            shift_reg;
        logic [TICK_WIDTH-1:0] tick_count;
        logic                  scl_reg;
        logic                  sda_reg;
        logic                  ack_reg;
        logic                  nack_request;
        logic [7:0]            rx_hold;
    } t_seq_state;

    t_seq_state r_st;
    t_seq_state n_st;
    logic       n_done;

    function automatic t_seq_state f_enter(t_seq_state s, t_phase p);
        t_seq_state o;
        o            = s;
        o.phase      = p;
        o.tick_count = '0;
        case (p)
            PH_ST_A: begin
                o.sda_reg = 1'b1;
            end
            PH_ST_B: begin
                o.scl_reg = 1'b1;
            end
            PH_ST_C: begin
                o.sda_reg = 1'b0;
            end
            PH_ST_D: begin
                o.scl_reg = 1'b0;
            end
            PH_SP_A: begin
                o.scl_reg = 1'b0;
                o.sda_reg = 1'b0;
            end
            PH_SP_B: begin
                o.scl_reg = 1'b1;
            end
            PH_SP_C: begin
                o.sda_reg = 1'b1;
            end
            PH_WR_LO: begin
                o.scl_reg = 1'b0;
                o.sda_reg = (s.bit_index < BITS_PER_BYTE) ? s.shift_reg[7] : 1'b1;
            end
            PH_RD_LO: begin
                o.scl_reg = 1'b0;
                o.sda_reg = (s.bit_index < BITS_PER_BYTE) ? 1'b1 : s.nack_request;
            end
            PH_WR_HI, PH_RD_HI: begin
                o.scl_reg = 1'b1;
            end
            default: begin
            end
        endcase
        return o;
    endfunction

    logic                  w_high;
    logic [TICK_WIDTH-1:0] w_len_raw;
    logic [TICK_WIDTH-1:0] w_len;
    logic [TICK_WIDTH-1:0] w_tick_next;
    logic                  w_expired;
    t_seq_state            w_tmp;

    always_comb begin
        w_high = r_st.phase inside {PH_ST_B, PH_ST_C, PH_SP_B, PH_SP_C, PH_WR_HI, PH_RD_HI};
        w_len_raw = w_high ? i_timing.high_ticks[TICK_WIDTH-1:0]
                           : i_timing.low_ticks[TICK_WIDTH-1:0];
        w_len = (w_len_raw == '0) ? TICK_WIDTH'(1) : w_len_raw;
        w_tick_next = r_st.tick_count + TICK_WIDTH'(1);
        w_expired = (w_tick_next >= w_len);
    end

    always_comb begin
        n_st   = r_st;
        n_done = 1'b0;
        w_tmp  = r_st;
        if (r_st.phase == PH_IDLE) begin
            if (i_word.command == CMD_START) begin
                n_st = f_enter(r_st, PH_ST_A);
            end else if (i_word.command == CMD_STOP) begin
                n_st = f_enter(r_st, PH_SP_A);
            end else if (i_word.command == CMD_WRITE) begin
                w_tmp.shift_reg = i_word.tx_byte;
                w_tmp.bit_index = '0;
                n_st = f_enter(w_tmp, PH_WR_LO);
            end else if (i_word.command == CMD_READ) begin
                w_tmp.nack_request = i_word.send_nack;
                w_tmp.shift_reg    = '0;
                w_tmp.bit_index    = '0;
                n_st = f_enter(w_tmp, PH_RD_LO);
            end
        end else begin
            n_st.tick_count = w_tick_next;
            w_tmp.tick_count = w_tick_next;
            if (w_expired) begin
                case (r_st.phase)
                    PH_ST_A: begin
                        n_st = f_enter(w_tmp, PH_ST_B);
                    end
                    PH_ST_B: begin
                        n_st = f_enter(w_tmp, PH_ST_C);
                    end
                    PH_ST_C: begin
                        n_st = f_enter(w_tmp, PH_ST_D);
                    end
                    PH_SP_A: begin
                        n_st = f_enter(w_tmp, PH_SP_B);
                    end
                    PH_SP_B: begin
                        n_st = f_enter(w_tmp, PH_SP_C);
                    end
                    PH_WR_LO: begin
                        n_st = f_enter(w_tmp, PH_WR_HI);
                    end
                    PH_RD_LO: begin
                        n_st = f_enter(w_tmp, PH_RD_HI);
                    end
                    PH_WR_HI: begin
                        if (r_st.bit_index >= BITS_PER_BYTE) begin
                            w_tmp.ack_reg = i_word.sda_in;
                            w_tmp.scl_reg = 1'b0;
                            n_st   = f_enter(w_tmp, PH_IDLE);
                            n_done = 1'b1;
                        end else begin
                            w_tmp.bit_index = r_st.bit_index + 4'd1;
                            w_tmp.shift_reg = {r_st.shift_reg[6:0], 1'b0};
                            n_st = f_enter(w_tmp, PH_WR_LO);
                        end
                    end
                    PH_RD_HI: begin
                        if (r_st.bit_index >= BITS_PER_BYTE) begin
                            w_tmp.rx_hold = r_st.shift_reg;
                            w_tmp.scl_reg = 1'b0;
                            n_st   = f_enter(w_tmp, PH_IDLE);
                            n_done = 1'b1;
                        end else begin
                            w_tmp.shift_reg = {r_st.shift_reg[6:0], i_word.sda_in};
                            w_tmp.bit_index = r_st.bit_index + 4'd1;
                            n_st = f_enter(w_tmp, PH_RD_LO);
                        end
                    end
                    default: begin
                        n_st   = f_enter(w_tmp, PH_IDLE);
                        n_done = 1'b1;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_result.scl_level = n_st.scl_reg;
        o_result.sda_level = n_st.sda_reg;
        o_result.busy_res  = (n_st.phase != PH_IDLE);
        o_result.done_res  = n_done;
        o_result.rx_byte   = n_st.rx_hold;
        o_result.ack_seen  = n_st.ack_reg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase        <= PH_IDLE;
            r_st.bit_index    <= '0;
            r_st.shift_reg    <= '0;
            r_st.tick_count   <= '0;
            r_st.scl_reg      <= 1'b1;
            r_st.sda_reg      <= 1'b1;
            r_st.ack_reg      <= 1'b0;
            r_st.nack_request <= 1'b0;
            r_st.rx_hold      <= '0;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

endmodule

`default_nettype wire

### rtl/i2cm_chk.sv
// ----------------------------------------------------------------------------
// i2cm_chk
// Port-level checks of the I2C master byte engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module i2cm_chk
    import i2cm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      o_in_stall,
    input  wire logic      o_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_word o_out_word
);

    logic w_done_busy;
    logic w_out_held;

    assign w_done_busy = o_out_word.done_res && o_out_word.busy_res;
    assign w_out_held  = o_out_valid && i_out_stall;

    `ASSERT_CLK(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall)
    `ASSERT_CLK_RST(a_stall_needs_output, i_clk, i_rst_n, o_in_stall |-> o_out_valid)
    `ASSERT_CLK_RST(a_done_not_busy, i_clk, i_rst_n, o_out_valid |-> !w_done_busy)
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, w_out_held |=> o_out_valid && $stable(o_out_word))

endmodule

bind i2c_master_byte_engine i2cm_chk u_chk (.*);

`default_nettype wire

### sim/i2c_master_byte_engine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine checker
// ----------------------------------------------------------------------------
// Watches the input, output and register ports of the engine. Every accepted
// input word is run through a cycle-exact model of the bit sequencer, and the
// resulting pin word is queued. Each accepted output word is compared field
// by field with the oldest queued one. Register writes update the model's
// SCL timing, and register reads are compared with it.
// ----------------------------------------------------------------------------

module i2c_master_byte_engine_checker
    import i2cm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_word              i_in_word,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_word             i_out_word,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [ADDR_WIDTH-1:0] i_paddr,
    input  logic [31:0]           i_pwdata,
    input  logic [31:0]           i_prdata,
    input  logic                  i_pready,
    output int                    o_fail_count,
    output int                    o_backlog
);

    t_phase                phase;
    logic [3:0]            bit_idx;
    logic [7:0]            shifter;
    logic [TICK_WIDTH-1:0] tick_cnt;
    logic                  scl_q;
    logic                  sda_q;
    logic                  ack_q;
    logic                  nack_q;
    logic [7:0]            rx_q;
    t_timing               timing;
    t_out_word             pin_words_due[$];
    int                    fail_count = 0;
    int                    backlog = 0;

    assign o_fail_count = fail_count;
    assign o_backlog    = backlog;

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [TICK_WIDTH-1:0] half_len(t_phase p);
        logic [TICK_WIDTH-1:0] v;
        case (p)
            PH_ST_B, PH_ST_C, PH_SP_B, PH_SP_C, PH_WR_HI, PH_RD_HI:
                v = TICK_WIDTH'(timing.high_ticks);
            default:
                v = TICK_WIDTH'(timing.low_ticks);
        endcase
        return (v == '0) ? TICK_WIDTH'(1) : v;
    endfunction

    function automatic void enter_phase(t_phase p);
        phase    = p;
        tick_cnt = '0;
        case (p)
            PH_ST_A: sda_q = 1'b1;
            PH_ST_B: scl_q = 1'b1;
            PH_ST_C: sda_q = 1'b0;
            PH_ST_D: scl_q = 1'b0;
            PH_SP_A: begin
                scl_q = 1'b0;
                sda_q = 1'b0;
            end
            PH_SP_B: scl_q = 1'b1;
            PH_SP_C: sda_q = 1'b1;
            PH_WR_LO: begin
                scl_q = 1'b0;
                sda_q = (bit_idx < BITS_PER_BYTE) ? shifter[7] : 1'b1;
            end
            PH_RD_LO: begin
                scl_q = 1'b0;
                sda_q = (bit_idx < BITS_PER_BYTE) ? 1'b1 : nack_q;
            end
            PH_WR_HI, PH_RD_HI: scl_q = 1'b1;
            default: ;
        endcase
    endfunction

    function automatic t_out_word engine_tick(t_in_word w);
        t_out_word r;
        logic      finished;
        finished = 1'b0;
        if (phase == PH_IDLE) begin
            case (w.command)
                CMD_START: enter_phase(PH_ST_A);
                CMD_STOP:  enter_phase(PH_SP_A);
                CMD_WRITE: begin
                    shifter = w.tx_byte;
                    bit_idx = '0;
                    enter_phase(PH_WR_LO);
                end
                CMD_READ: begin
                    nack_q  = w.send_nack;
                    shifter = '0;
                    bit_idx = '0;
                    enter_phase(PH_RD_LO);
                end
                default: ;
            endcase
        end else begin
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= half_len(phase)) begin
                case (phase)
                    PH_ST_A:  enter_phase(PH_ST_B);
                    PH_ST_B:  enter_phase(PH_ST_C);
                    PH_ST_C:  enter_phase(PH_ST_D);
                    PH_SP_A:  enter_phase(PH_SP_B);
                    PH_SP_B:  enter_phase(PH_SP_C);
                    PH_WR_LO: enter_phase(PH_WR_HI);
                    PH_RD_LO: enter_phase(PH_RD_HI);
                    PH_WR_HI: begin
                        if (bit_idx >= BITS_PER_BYTE) begin
                            ack_q = w.sda_in;
                            scl_q = 1'b0;
                            enter_phase(PH_IDLE);
                            finished = 1'b1;
                        end else begin
                            bit_idx = bit_idx + 1'b1;
                            shifter = {shifter[6:0], 1'b0};
                            enter_phase(PH_WR_LO);
                        end
                    end
                    PH_RD_HI: begin
                        if (bit_idx >= BITS_PER_BYTE) begin
                            rx_q  = shifter;
                            scl_q = 1'b0;
                            enter_phase(PH_IDLE);
                            finished = 1'b1;
                        end else begin
                            shifter = {shifter[6:0], w.sda_in};
                            bit_idx = bit_idx + 1'b1;
                            enter_phase(PH_RD_LO);
                        end
                    end
                    default: begin
                        enter_phase(PH_IDLE);
                        finished = 1'b1;
                    end
                endcase
            end
        end
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.busy_res  = (phase != PH_IDLE);
        r.done_res  = finished;
        r.rx_byte   = rx_q;
        r.ack_seen  = ack_q;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word  due;
        t_reg_index idx;
        logic [CFG_WIDTH-1:0] stored;
        if (!i_rst_n) begin
            phase    = PH_IDLE;
            bit_idx  = '0;
            shifter  = '0;
            tick_cnt = '0;
            scl_q    = 1'b1;
            sda_q    = 1'b1;
            ack_q    = 1'b0;
            nack_q   = 1'b0;
            rx_q     = '0;
            timing.high_ticks = RESET_HIGH_TICKS;
            timing.low_ticks  = RESET_LOW_TICKS;
            pin_words_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pin_words_due.size() == 0) begin
                    $error("output word %h arrived with none expected", i_out_word);
                    fail_count++;
                end else begin
                    due = pin_words_due.pop_front();
                    check_field("scl_level", 32'(due.scl_level), 32'(i_out_word.scl_level));
                    check_field("sda_level", 32'(due.sda_level), 32'(i_out_word.sda_level));
                    check_field("busy_res", 32'(due.busy_res), 32'(i_out_word.busy_res));
                    check_field("done_res", 32'(due.done_res), 32'(i_out_word.done_res));
                    check_field("rx_byte", 32'(due.rx_byte), 32'(i_out_word.rx_byte));
                    check_field("ack_seen", 32'(due.ack_seen), 32'(i_out_word.ack_seen));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pin_words_due.push_back(engine_tick(i_in_word));
            end
            if (i_psel && i_penable && i_pready) begin
                idx    = t_reg_index'(i_paddr[2]);
                stored = (idx == REG_SCL_HIGH) ? timing.high_ticks : timing.low_ticks;
                if (i_pwrite) begin
                    if (idx == REG_SCL_HIGH) begin
                        timing.high_ticks = i_pwdata[CFG_WIDTH-1:0];
                    end else begin
                        timing.low_ticks = i_pwdata[CFG_WIDTH-1:0];
                    end
                end else begin
                    check_field("prdata", 32'(stored), i_prdata);
                end
            end
        end
        backlog = pin_words_due.size();
    end

endmodule

### sim/i2c_master_byte_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine testbench
// ----------------------------------------------------------------------------
// Drives tick words into the engine: a short directed run of every command,
// the undefined codes and commands sent while busy, a partial start at the
// longest high time, then random command sequences padded with idle ticks
// under several SCL timings, including zero. Both sides idle and stall at
// varied rates, and one phase holds the output off long enough to back up
// the input. A separate checker predicts and compares; this module only
// generates stimulus and reports.
// ----------------------------------------------------------------------------

module i2c_master_byte_engine_tb;
    import i2cm_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int END_CYCLES  = 8;
    localparam int HOLD_CYCLES = 48;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_word              i_in_word;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_word             o_out_word;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int          fail_count;
    int          backlog;
    int          quiet_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          squeeze_on = 1'b0;
    bit          holding = 1'b0;
    int          hold_left = 0;
    int unsigned phase_words = 0;
    int unsigned high_eff = 1;
    int unsigned low_eff = 1;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    i2c_master_byte_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    i2c_master_byte_engine_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_word   (o_out_word),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_backlog    (backlog)
    );

    always @(negedge i_clk) begin
        if (squeeze_on) begin
            if (hold_left == 0) begin
                holding   = !holding;
                hold_left = holding ? HOLD_CYCLES : int'($urandom_range(40, 4));
            end
            hold_left--;
            i_out_stall <= holding;
        end else begin
            holding   = 1'b0;
            hold_left = 0;
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        phase_words++;
        @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input t_reg_index idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_timing(input logic [CFG_WIDTH-1:0] high, input logic [CFG_WIDTH-1:0] low);
        i_in_valid <= 1'b0;
        while (backlog != 0) @(negedge i_clk);
        apb_access(1'b1, REG_SCL_HIGH, ($urandom() & 32'hFFFF_FC00) | 32'(high));
        apb_access(1'b1, REG_SCL_LOW, ($urandom() & 32'hFFFF_FC00) | 32'(low));
        apb_access(1'b0, REG_SCL_HIGH, '0);
        apb_access(1'b0, REG_SCL_LOW, '0);
        high_eff = (high == '0) ? 1 : high;
        low_eff  = (low == '0) ? 1 : low;
    endtask

    function automatic int unsigned command_span(t_cmd cmd);
        case (cmd)
            CMD_START:           return 2 * (high_eff + low_eff);
            CMD_STOP:            return low_eff + 2 * high_eff;
            CMD_WRITE, CMD_READ: return 9 * (high_eff + low_eff);
            default:             return 0;
        endcase
    endfunction

    task automatic run_command(input t_cmd cmd, input logic [7:0] tx, input logic nack,
                               input int extra, input int unsigned noise_pct);
        t_in_word w;
        int       fillers;
        w.command   = cmd;
        w.tx_byte   = tx;
        w.send_nack = nack;
        w.sda_in    = 1'($urandom_range(1));
        send_word(w);
        fillers = int'(command_span(cmd)) + extra;
        if (fillers < 0) begin
            fillers = 0;
        end
        repeat (fillers) begin
            w.command   = ($urandom_range(99) < noise_pct) ? 3'($urandom_range(7)) : CMD_NONE;
            w.tx_byte   = 8'($urandom());
            w.send_nack = 1'($urandom_range(1));
            w.sda_in    = 1'($urandom_range(1));
            send_word(w);
        end
    endtask

    task automatic random_sequence();
        t_cmd        cmd;
        int unsigned span;
        int          extra;
        if ($urandom_range(99) < 85) begin
            case ($urandom_range(3))
                0:       cmd = CMD_START;
                1:       cmd = CMD_STOP;
                2:       cmd = CMD_WRITE;
                default: cmd = CMD_READ;
            endcase
            span  = command_span(cmd);
            extra = ($urandom_range(9) < 8) ? int'($urandom_range(2)) : -int'($urandom_range(span));
            run_command(cmd, 8'($urandom()), 1'($urandom_range(1)), extra, 8);
        end else begin
            send_word(t_in_word'(13'($urandom())));
        end
    endtask

    task automatic run_phase(input logic [CFG_WIDTH-1:0] high, input logic [CFG_WIDTH-1:0] low,
                             input int unsigned send_pct, input int unsigned recv_pct,
                             input bit squeeze, input int unsigned budget);
        set_timing(high, low);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        squeeze_on     = squeeze;
        phase_words    = 0;
        while (phase_words < budget) random_sequence();
    endtask

    initial begin
        t_in_word w;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        apb_access(1'b0, REG_SCL_HIGH, '0);
        apb_access(1'b0, REG_SCL_LOW, '0);
        set_timing(10'd1, 10'd1);

        for (int code = CMD_NONE; code < 8; code++) begin
            if (code == CMD_NONE || code > CMD_READ) begin
                w.command   = 3'(code);
                w.tx_byte   = (code[0]) ? 8'hFF : 8'h00;
                w.send_nack = code[1];
                w.sda_in    = code[0];
                send_word(w);
            end
        end
        run_command(CMD_START, 8'h00, 1'b0, 0, 100);
        run_command(CMD_WRITE, 8'hFF, 1'b1, 0, 0);
        run_command(CMD_READ, 8'h00, 1'b1, 0, 0);
        run_command(CMD_STOP, 8'h5A, 1'b0, 0, 0);

        set_timing(10'd1023, 10'd1);
        run_command(CMD_START, 8'h00, 1'b0, -2000, 0);

        run_phase(10'd1, 10'd1, 0, 0, 1'b0, 120);
        run_phase(10'd2, 10'd3, 81, 0, 1'b0, 100);
        run_phase(10'd0, 10'd0, 0, 81, 1'b0, 100);
        run_phase(10'd3, 10'd1, 11, 11, 1'b0, 100);
        run_phase(10'd4, 10'd2, 0, 0, 1'b1, 120);
        run_phase(10'd5, 10'd8, 0, 0, 1'b0, 80);

        i_in_valid <= 1'b0;
        while (backlog != 0) @(negedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### i2c_master_byte_engine.f
+incdir+rtl
rtl/i2cm_pkg.sv
rtl/i2cm_seq.sv
rtl/i2c_master_byte_engine.sv
rtl/i2cm_chk.sv
sim/i2c_master_byte_engine_checker.sv
sim/i2c_master_byte_engine_tb.sv
